@@ rtl/pgpm_pkg.sv @@
// ----------------------------------------------------------------------------
// pgpm_pkg: shared types, constants and helpers
// holds the mix mode codes, register indexes, reset values and the per
// channel mixing function used by the top level
// ----------------------------------------------------------------------------
package pgpm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LIGHT_POS_W = 14;
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned INTENS_W   = 16;
  localparam int unsigned PROD_W     = COLOR_W + INTENS_W;  // c * intensity
  localparam int unsigned QUOT_W     = 2 * PROD_W - 16;     // (c*i)^2 / 65536
  localparam int unsigned DIST_W     = QUOT_W + 1;          // clamped squared distance
  localparam int unsigned SQ_W       = 2 * COLOR_W;
  localparam int unsigned NUM_LANES  = 3;

  typedef enum logic [2:0] {
    MIX_XOR   = 3'd0,
    MIX_AVG   = 3'd1,
    MIX_ADD   = 3'd2,
    MIX_SUB   = 3'd3,
    MIX_MUL   = 3'd4,
    MIX_AND   = 3'd5,
    MIX_OR    = 3'd6,
    MIX_PASS  = 3'd7
  } mix_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X     = 3'd0,
    REG_LIGHT_Y     = 3'd1,
    REG_LIGHT_RED   = 3'd2,
    REG_LIGHT_GREEN = 3'd3,
    REG_LIGHT_BLUE  = 3'd4,
    REG_INTENSITY   = 3'd5,
    REG_MIX_MODE    = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_e;

  localparam logic [INTENS_W-1:0] INTENSITY_RST = 16'd5120;
  localparam mix_mode_e           MIX_MODE_RST  = MIX_ADD;

  function automatic logic [COLOR_W-1:0] mix_channel(
    input mix_mode_e          mode,
    input logic [COLOR_W-1:0] glow,
    input logic [COLOR_W-1:0] prior
  );
    logic [COLOR_W:0]     sum;
    logic [2*COLOR_W-1:0] mul;
    logic [COLOR_W-1:0]   r;
    sum = {1'b0, glow} + {1'b0, prior};
    mul = glow * prior;
    case (mode)
      MIX_XOR:   r = glow ^ prior;
      MIX_AVG:   r = sum[COLOR_W:1];
      MIX_ADD:   r = sum[COLOR_W] ? {COLOR_W{1'b1}} : sum[COLOR_W-1:0];
      MIX_SUB:   r = (glow > prior) ? (glow - prior) : '0;
      MIX_MUL:   r = (|mul[2*COLOR_W-1:COLOR_W]) ? {COLOR_W{1'b1}} : mul[COLOR_W-1:0];
      MIX_AND:   r = glow & prior;
      MIX_OR:    r = glow | prior;
      default:   r = glow;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/pgpm_dist.sv @@
// ----------------------------------------------------------------------------
// pgpm_dist: squared distance pipeline
// two stages: absolute offsets, then sum of squares clamped to DIST_W bits
// ----------------------------------------------------------------------------
module pgpm_dist #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic [COORD_BITS-1:0]                 px_i,
  input  logic [COORD_BITS-1:0]                 py_i,
  input  logic signed [pgpm_pkg::LIGHT_POS_W-1:0] light_x_i,
  input  logic signed [pgpm_pkg::LIGHT_POS_W-1:0] light_y_i,
  output logic [pgpm_pkg::DIST_W-1:0]           dist_o,
  output logic                                  dzero_o
);
  import pgpm_pkg::*;

  localparam int unsigned AW  = ((COORD_BITS > LIGHT_POS_W - 1) ? COORD_BITS
                                                               : LIGHT_POS_W - 1) + 1;
  localparam int unsigned SW  = AW + 1;
  localparam int unsigned D2W = 2 * AW + 1;
  localparam int unsigned DXW = (D2W > DIST_W) ? D2W : DIST_W + 1;

  logic signed [SW-1:0] dx, dy;
  logic [AW-1:0]        adx_d, ady_d, adx_q, ady_q;
  logic [D2W-1:0]       d2;
  logic [DXW-1:0]       d2_ext;
  logic [DIST_W-1:0]    dist_d, dist_q;
  logic                 dzero_q;

  assign dx = $signed(SW'(px_i)) - SW'(light_x_i);
  assign dy = $signed(SW'(py_i)) - SW'(light_y_i);
  assign adx_d = dx[SW-1] ? AW'(-dx) : AW'(dx);
  assign ady_d = dy[SW-1] ? AW'(-dy) : AW'(dy);

  assign d2     = D2W'(adx_q) * D2W'(adx_q) + D2W'(ady_q) * D2W'(ady_q);
  assign d2_ext = DXW'(d2);
  // beyond the quotient range every nonzero glow fails, so clamp
  assign dist_d = (|d2_ext[DXW-1:DIST_W-1]) ? {1'b1, {(DIST_W-1){1'b0}}}
                                           : d2_ext[DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx_q   <= adx_d;
      ady_q   <= ady_d;
      dist_q  <= dist_d;
      dzero_q <= (d2 == '0);
    end
  end

  assign dist_o  = dist_q;
  assign dzero_o = dzero_q;

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

@@ rtl/pgpm_lane.sv @@
// ----------------------------------------------------------------------------
// pgpm_lane: glow of one colour channel
// squares the scaled colour, then finds the glow one bit per stage
// ----------------------------------------------------------------------------
module pgpm_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic [pgpm_pkg::COLOR_W-1:0]      color_i,
  input  logic [pgpm_pkg::INTENS_W-1:0]     intensity_i,
  input  logic [pgpm_pkg::DIST_W-1:0]       dist_i,
  input  logic                              dzero_i,
  output logic [pgpm_pkg::COLOR_W-1:0]      glow_o
);
  import pgpm_pkg::*;

  localparam int unsigned STEPS = COLOR_W;
  localparam int unsigned MW    = SQ_W + DIST_W;

  logic [PROD_W-1:0]   p_q;
  logic [QUOT_W-1:0]   q_q;
  logic                pnz_q;
  logic [2*PROD_W-1:0] p_sq;

  assign p_sq = p_q * p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= color_i * intensity_i;
      q_q   <= p_sq[2*PROD_W-1:16];
      pnz_q <= (p_q != '0);
    end
  end

  // per-stage registers of the bit search
  logic [COLOR_W-1:0] n_q    [0:STEPS-1];
  logic [SQ_W-1:0]    sq_q   [0:STEPS-1];
  logic [DIST_W-1:0]  d_q    [0:STEPS-1];
  logic [QUOT_W-1:0]  qv_q   [0:STEPS-1];
  logic               dz_q   [0:STEPS-1];
  logic               pnz_s_q[0:STEPS-1];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int unsigned K = STEPS - 1 - j;
    logic [COLOR_W-1:0] n_in;
    logic [SQ_W-1:0]    sq_in;
    logic [DIST_W-1:0]  d_in;
    logic [QUOT_W-1:0]  q_in;
    logic               dz_in, pnz_in;
    logic [SQ_W:0]      t2;
    logic [MW-1:0]      prod;
    logic               fit;

    if (j == 0) begin : g_first
      assign n_in   = '0;
      assign sq_in  = '0;
      assign d_in   = dist_i;
      assign q_in   = q_q;
      assign dz_in  = dzero_i;
      assign pnz_in = pnz_q;
    end else begin : g_next
      assign n_in   = n_q[j-1];
      assign sq_in  = sq_q[j-1];
      assign d_in   = d_q[j-1];
      assign q_in   = qv_q[j-1];
      assign dz_in  = dz_q[j-1];
      assign pnz_in = pnz_s_q[j-1];
    end

    // (n | 2^k)^2 = n^2 + n*2^(k+1) + 2^(2k), low bits of n are still clear
    assign t2   = (SQ_W+1)'(sq_in) + ((SQ_W+1)'(n_in) << (K + 1))
                + ((SQ_W+1)'(1) << (2 * K));
    assign prod = t2[SQ_W-1:0] * d_in;
    assign fit  = (prod <= MW'(q_in));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]     <= fit ? (n_in | COLOR_W'(1 << K)) : n_in;
        sq_q[j]    <= fit ? t2[SQ_W-1:0] : sq_in;
        d_q[j]     <= d_in;
        qv_q[j]    <= q_in;
        dz_q[j]    <= dz_in;
        pnz_s_q[j] <= pnz_in;
      end
    end
  end

  assign glow_o = dz_q[STEPS-1] ? (pnz_s_q[STEPS-1] ? {COLOR_W{1'b1}} : '0)
                                : n_q[STEPS-1];

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

@@ rtl/point_glow_pixel_mixer_top.sv @@
// ----------------------------------------------------------------------------
// point_glow_pixel_mixer_top: point light glow mixed into a pixel stream
// three colour lanes search the glow in parallel, the output stage merges
// them with the prior colour by the selected mix mode
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// s_axis   | in  | tdata: pixel_x, pixel_y, prior_red, prior_green, prior_blue
// m_axis   | out | tdata: out_red, out_green, out_blue
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i; one register per write
//
// one pixel per clock sustained while m_axis accepts; the 8-stage glow bit
// search per lane sits behind the input, offset and distance registers and colour squaring
// reset clears the valid pipeline and loads the register reset values
// the whole pipeline stalls while a result waits unaccepted at m_axis
// ----------------------------------------------------------------------------
module point_glow_pixel_mixer_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_x, pixel_y, prior_red, prior_green, prior_blue, zero fill
  input  logic [((2*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0]                         m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [pgpm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pgpm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pgpm_pkg::*;

  localparam int unsigned IN_W  = ((2 * COORD_BITS + 24 + 7) / 8) * 8;
  localparam int unsigned DEPTH = 3 + COLOR_W;  // stages before the output

  // configuration registers
  logic signed [LIGHT_POS_W-1:0] light_x_q, light_y_q;
  logic [COLOR_W-1:0]            color_q [0:NUM_LANES-1];
  logic [INTENS_W-1:0]           intensity_q;
  mix_mode_e                     mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q   <= '0;
      light_y_q   <= '0;
      color_q[0]  <= '0;
      color_q[1]  <= '0;
      color_q[2]  <= '0;
      intensity_q <= INTENSITY_RST;
      mode_q      <= MIX_MODE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LIGHT_X:     light_x_q   <= cfg_data_i[LIGHT_POS_W-1:0];
        REG_LIGHT_Y:     light_y_q   <= cfg_data_i[LIGHT_POS_W-1:0];
        REG_LIGHT_RED:   color_q[0]  <= cfg_data_i[COLOR_W-1:0];
        REG_LIGHT_GREEN: color_q[1]  <= cfg_data_i[COLOR_W-1:0];
        REG_LIGHT_BLUE:  color_q[2]  <= cfg_data_i[COLOR_W-1:0];
        REG_INTENSITY:   intensity_q <= cfg_data_i[INTENS_W-1:0];
        REG_MIX_MODE:    mode_q      <= mix_mode_e'(cfg_data_i[2:0]);
        default:         ;
      endcase
    end
  end

  // global advance: move when the output slot is free or being drained
  logic en;
  logic out_valid_q;
  logic [DEPTH-1:0] v_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[DEPTH-2:0], s_axis_tvalid};
      out_valid_q <= v_q[DEPTH-1];
    end
  end

  // input stage and prior colour delay line
  logic [COORD_BITS-1:0] px_q, py_q;
  logic [3*COLOR_W-1:0]  prior_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q       <= s_axis_tdata[COORD_BITS-1:0];
      py_q       <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
      prior_q[0] <= s_axis_tdata[2*COORD_BITS+3*COLOR_W-1:2*COORD_BITS];
      for (int i = 1; i < DEPTH; i++) begin
        prior_q[i] <= prior_q[i-1];
      end
    end
  end

  logic unused_fill;
  if (IN_W > 2 * COORD_BITS + 3 * COLOR_W) begin : g_fill
    assign unused_fill = |s_axis_tdata[IN_W-1:2*COORD_BITS+3*COLOR_W];
  end else begin : g_nofill
    assign unused_fill = 1'b0;
  end

  // shared distance pipeline
  logic [DIST_W-1:0] dist_sq;
  logic              dzero;

  pgpm_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .px_i      (px_q),
    .py_i      (py_q),
    .light_x_i (light_x_q),
    .light_y_i (light_y_q),
    .dist_o    (dist_sq),
    .dzero_o   (dzero)
  );

  // one lane per colour channel
  logic [COLOR_W-1:0] glow [0:NUM_LANES-1];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    pgpm_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .color_i     (color_q[l]),
      .intensity_i (intensity_q),
      .dist_i      (dist_sq),
      .dzero_i     (dzero),
      .glow_o      (glow[l])
    );
  end

  // merge stage: mix each lane with its prior channel
  logic [23:0] out_d, out_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_mix
    assign out_d[l*COLOR_W +: COLOR_W] =
      mix_channel(mode_q, glow[l], prior_q[DEPTH-1][l*COLOR_W +: COLOR_W]);
  end

  always_ff @(posedge clk_i) begin
    if (en && v_q[DEPTH-1]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
